### design/msctb_pkg.sv
// ----------------------------------------------------------------------------
// msctb_pkg
// Shared types and codes for the countdown timer slot bank.
// ----------------------------------------------------------------------------
package msctb_pkg;

	localparam int MAX_RESULTS = 16;
	localparam int CNT_W       = $clog2(MAX_RESULTS + 1);

	typedef enum logic [1:0] {
		KIND_TICK  = 2'd0,
		KIND_START = 2'd1,
		KIND_STOP  = 2'd2
	} req_kind_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SWEEP,
		ST_FLUSH
	} ctl_state_t;

	typedef struct packed {
		logic active;
		logic one_shot;
	} slot_flags_t;

	typedef struct packed {
		logic busy;
		logic shift;
	} ring_ctl_t;

endpackage

### design/msctb_cell.sv
// ----------------------------------------------------------------------------
// msctb_cell
// One timer slot of the ring: flags, interval and remaining count. Takes its
// neighbor's contents on shift, or a start/stop request while the ring rests.
// ----------------------------------------------------------------------------
module msctb_cell #(
	parameter int TIME_BITS = 32
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   shift,
	input  logic                   load,
	input  logic                   clear,
	input  logic                   load_one_shot,
	input  logic [TIME_BITS-1:0]   load_interval,
	input  msctb_pkg::slot_flags_t nb_flags,
	input  logic [TIME_BITS-1:0]   nb_interval,
	input  logic [TIME_BITS-1:0]   nb_remaining,
	output msctb_pkg::slot_flags_t flags,
	output logic [TIME_BITS-1:0]   interval_val,
	output logic [TIME_BITS-1:0]   remaining_val
);
	import msctb_pkg::*;

	slot_flags_t          flags_q;
	logic [TIME_BITS-1:0] interval_q;
	logic [TIME_BITS-1:0] remaining_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			flags_q <= '0;
		end else if (shift) begin
			flags_q <= nb_flags;
		end else if (load) begin
			flags_q.active   <= 1'b1;
			flags_q.one_shot <= load_one_shot;
		end else if (clear) begin
			flags_q.active <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (shift) begin
			interval_q  <= nb_interval;
			remaining_q <= nb_remaining;
		end else if (load) begin
			interval_q  <= load_interval;
			remaining_q <= load_interval;
		end
	end

	assign flags         = flags_q;
	assign interval_val  = interval_q;
	assign remaining_val = remaining_q;

endmodule

### design/msctb_ctrl.sv
// ----------------------------------------------------------------------------
// msctb_ctrl
// Tick sequencer: rotates the ring once, updates the slot at the head,
// holds one pending expiry to mark the last one, and drives the result
// register.
// ----------------------------------------------------------------------------
module msctb_ctrl #(
	parameter int NUM_SLOTS = 16,
	parameter int TIME_BITS = 32
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   tick_go,
	input  msctb_pkg::slot_flags_t head_flags,
	input  logic [TIME_BITS-1:0]   head_interval,
	input  logic [TIME_BITS-1:0]   head_remaining,
	output msctb_pkg::slot_flags_t ret_flags,
	output logic [TIME_BITS-1:0]   ret_interval,
	output logic [TIME_BITS-1:0]   ret_remaining,
	output msctb_pkg::ring_ctl_t   ring_ctl,
	input  logic                   out_stall,
	output logic                   out_valid,
	output logic [3:0]             expired_slot,
	output logic                   was_one_shot,
	output logic                   last
);
	import msctb_pkg::*;

	localparam int PW = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
	localparam logic [PW-1:0] POS_LAST = PW'(NUM_SLOTS - 1);

	ctl_state_t       state_q, state_d;
	logic [PW-1:0]    pos_q;
	logic [CNT_W-1:0] cnt_q;
	logic             pend_valid_q;
	logic [PW-1:0]    pend_slot_q;
	logic             pend_one_shot_q;
	logic             out_valid_q;
	logic [3:0]       out_slot_q;
	logic             out_one_shot_q;
	logic             out_last_q;

	logic [TIME_BITS-1:0] dec;
	logic                 expire;
	logic                 report;
	logic                 out_free;
	logic                 shift;
	logic                 push;
	logic                 push_last;
	logic                 pend_load;
	logic                 pend_drop;
	logic [PW+3:0]        pend_slot_ext;

	assign dec      = head_remaining - 1'b1;
	assign expire   = head_flags.active && (dec == '0);
	assign report   = cnt_q < CNT_W'(MAX_RESULTS);
	assign out_free = !out_valid_q || !out_stall;

	always_comb begin
		ret_interval      = head_interval;
		ret_flags         = head_flags;
		ret_remaining     = head_flags.active ? dec : head_remaining;
		if (expire) begin
			if (head_flags.one_shot) begin
				ret_flags.active = 1'b0;
			end else begin
				ret_remaining = head_interval;
			end
		end
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (tick_go) begin
					state_d = ST_SWEEP;
				end
			end
			ST_SWEEP: begin
				if (shift && pos_q == POS_LAST) begin
					state_d = ST_FLUSH;
				end
			end
			ST_FLUSH: begin
				if (!pend_valid_q || out_free) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		shift     = 1'b0;
		push      = 1'b0;
		push_last = 1'b0;
		pend_load = 1'b0;
		pend_drop = 1'b0;
		case (state_q)
			ST_SWEEP: begin
				if (expire && report && pend_valid_q) begin
					push  = out_free;
					shift = out_free;
				end else begin
					shift = 1'b1;
				end
				pend_load = shift && expire && report;
			end
			ST_FLUSH: begin
				if (pend_valid_q && out_free) begin
					push      = 1'b1;
					push_last = 1'b1;
					pend_drop = 1'b1;
				end
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			pos_q        <= '0;
			cnt_q        <= '0;
			pend_valid_q <= 1'b0;
			out_valid_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			if (tick_go) begin
				pos_q <= '0;
				cnt_q <= '0;
			end else if (shift) begin
				pos_q <= (pos_q == POS_LAST) ? '0 : pos_q + 1'b1;
				if (pend_load) begin
					cnt_q <= cnt_q + 1'b1;
				end
			end
			if (pend_load) begin
				pend_valid_q <= 1'b1;
			end else if (pend_drop) begin
				pend_valid_q <= 1'b0;
			end
			if (push) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign pend_slot_ext = {4'b0, pend_slot_q};

	always_ff @(posedge clk) begin
		if (pend_load) begin
			pend_slot_q     <= pos_q;
			pend_one_shot_q <= head_flags.one_shot;
		end
		if (push) begin
			out_slot_q     <= pend_slot_ext[3:0];
			out_one_shot_q <= pend_one_shot_q;
			out_last_q     <= push_last;
		end
	end

	assign ring_ctl.busy  = (state_q != ST_IDLE);
	assign ring_ctl.shift = shift;
	assign out_valid      = out_valid_q;
	assign expired_slot   = out_slot_q;
	assign was_one_shot   = out_one_shot_q;
	assign last           = out_last_q;

endmodule

### design/multi_slot_countdown_timer_bank_unit.sv
// ----------------------------------------------------------------------------
// multi_slot_countdown_timer_bank_unit
// Bank of one-shot / periodic countdown timers held in a rotating ring of
// slot cells; a tick walks every slot past the head update once.
// ----------------------------------------------------------------------------
//  channel  signals                                      direction
//  in       in_valid/in_stall kind slot interval one_shot  request in
//  out      out_valid/out_stall expired_slot was_one_shot last  result out
//
//  Start and stop load or clear the slot directly. A tick rotates the ring
//  one slot per cycle while out_stall does not hold a full result register,
//  then a flush state passes on the last pending result.
//  Reset clears all active and one-shot flags at once; no clearing pass.
//  in_stall is high for the whole tick sweep.
// ----------------------------------------------------------------------------
module multi_slot_countdown_timer_bank_unit #(
	parameter int NUM_SLOTS = 16,
	parameter int TIME_BITS = 32
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [1:0]  kind,
	input  logic [3:0]  slot,
	input  logic [31:0] interval,
	input  logic        one_shot,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [3:0]  expired_slot,
	output logic        was_one_shot,
	output logic        last
);
	import msctb_pkg::*;

	ring_ctl_t            ring_ctl;
	logic                 in_acc;
	logic                 tick_go;
	logic                 start_go;
	logic                 stop_go;
	logic [TIME_BITS+31:0] interval_ext;
	logic [TIME_BITS-1:0]  load_interval;
	logic [NUM_SLOTS-1:0]  load;

	slot_flags_t          flags     [NUM_SLOTS];
	logic [TIME_BITS-1:0] intervals [NUM_SLOTS];
	logic [TIME_BITS-1:0] remains   [NUM_SLOTS];

	slot_flags_t          ret_flags;
	logic [TIME_BITS-1:0] ret_interval;
	logic [TIME_BITS-1:0] ret_remaining;

	assign in_stall      = ring_ctl.busy;
	assign in_acc        = in_valid && !in_stall;
	assign tick_go       = in_acc && (kind == KIND_TICK);
	assign start_go      = in_acc && (kind == KIND_START);
	assign stop_go       = in_acc && (kind == KIND_STOP);
	assign interval_ext  = {{TIME_BITS{1'b0}}, interval};
	assign load_interval = interval_ext[TIME_BITS-1:0];

	for (genvar k = 0; k < NUM_SLOTS; k++) begin : g_ring
		slot_flags_t          nb_flags;
		logic [TIME_BITS-1:0] nb_interval;
		logic [TIME_BITS-1:0] nb_remaining;
		logic                 hit;

		assign hit     = (32'(slot) == k);
		assign load[k] = start_go && hit;

		if (k == NUM_SLOTS - 1) begin : g_tail
			assign nb_flags     = ret_flags;
			assign nb_interval  = ret_interval;
			assign nb_remaining = ret_remaining;
		end else begin : g_mid
			assign nb_flags     = flags[k+1];
			assign nb_interval  = intervals[k+1];
			assign nb_remaining = remains[k+1];
		end

		msctb_cell #(
			.TIME_BITS(TIME_BITS)
		) u_cell (
			.clk           (clk),
			.arst_n        (arst_n),
			.shift         (ring_ctl.shift),
			.load          (load[k]),
			.clear         (stop_go && hit),
			.load_one_shot (one_shot),
			.load_interval (load_interval),
			.nb_flags      (nb_flags),
			.nb_interval   (nb_interval),
			.nb_remaining  (nb_remaining),
			.flags         (flags[k]),
			.interval_val  (intervals[k]),
			.remaining_val (remains[k])
		);
	end

	msctb_ctrl #(
		.NUM_SLOTS(NUM_SLOTS),
		.TIME_BITS(TIME_BITS)
	) u_ctrl (
		.clk            (clk),
		.arst_n         (arst_n),
		.tick_go        (tick_go),
		.head_flags     (flags[0]),
		.head_interval  (intervals[0]),
		.head_remaining (remains[0]),
		.ret_flags      (ret_flags),
		.ret_interval   (ret_interval),
		.ret_remaining  (ret_remaining),
		.ring_ctl       (ring_ctl),
		.out_stall      (out_stall),
		.out_valid      (out_valid),
		.expired_slot   (expired_slot),
		.was_one_shot   (was_one_shot),
		.last           (last)
	);

`ifndef NO_ASSERTIONS
	a_tick_busy: assert property (@(posedge clk) disable iff (!arst_n)
		tick_go |=> in_stall)
		else $error("tick request did not start a sweep");

	a_no_load_in_sweep: assert property (@(posedge clk) disable iff (!arst_n)
		ring_ctl.shift |-> (load == '0))
		else $error("slot load during ring rotation");

	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(in_stall) |-> $past(in_valid) && $past(kind) == KIND_TICK)
		else $error("sweep started without a tick request");
`endif

endmodule
